[rtl/core/md5_hash_core_top_defines.svh]
// Assertion macros for the MD5 core.
// Included by md5_hash_core_top; needs clk and rst_n in scope.
`ifndef MD5_HASH_CORE_TOP_DEFINES_SVH
`define MD5_HASH_CORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MD5HC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MD5HC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MD5HC_ASSERT(lbl, prop, msg)
`define MD5HC_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/core/md5hc_pkg.sv]
// Shared constants, types and functions of the MD5 core.
// No dependencies.
`default_nettype none

package md5hc_pkg;

    localparam logic [3:0][31:0] IV = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LAST_POS = 4'd15;
    localparam logic [3:0] LEN_POS  = 4'd14;
    localparam logic [5:0] LAST_STEP = 6'd63;
    localparam logic [2:0] FULL_BYTES = 3'd4;

    typedef struct packed {
        logic load;   // round regs <= chain
        logic step;   // one MD5 step
        logic fin;    // chain += round regs
        logic clear;  // chain <= IV
    } ctrl_t;

    function automatic logic [31:0] step_const(input logic [5:0] k);
        logic [31:0] c;
        case (k)
            6'd0:  c = 32'hd76aa478;  6'd1:  c = 32'he8c7b756;
            6'd2:  c = 32'h242070db;  6'd3:  c = 32'hc1bdceee;
            6'd4:  c = 32'hf57c0faf;  6'd5:  c = 32'h4787c62a;
            6'd6:  c = 32'ha8304613;  6'd7:  c = 32'hfd469501;
            6'd8:  c = 32'h698098d8;  6'd9:  c = 32'h8b44f7af;
            6'd10: c = 32'hffff5bb1;  6'd11: c = 32'h895cd7be;
            6'd12: c = 32'h6b901122;  6'd13: c = 32'hfd987193;
            6'd14: c = 32'ha679438e;  6'd15: c = 32'h49b40821;
            6'd16: c = 32'hf61e2562;  6'd17: c = 32'hc040b340;
            6'd18: c = 32'h265e5a51;  6'd19: c = 32'he9b6c7aa;
            6'd20: c = 32'hd62f105d;  6'd21: c = 32'h02441453;
            6'd22: c = 32'hd8a1e681;  6'd23: c = 32'he7d3fbc8;
            6'd24: c = 32'h21e1cde6;  6'd25: c = 32'hc33707d6;
            6'd26: c = 32'hf4d50d87;  6'd27: c = 32'h455a14ed;
            6'd28: c = 32'ha9e3e905;  6'd29: c = 32'hfcefa3f8;
            6'd30: c = 32'h676f02d9;  6'd31: c = 32'h8d2a4c8a;
            6'd32: c = 32'hfffa3942;  6'd33: c = 32'h8771f681;
            6'd34: c = 32'h6d9d6122;  6'd35: c = 32'hfde5380c;
            6'd36: c = 32'ha4beea44;  6'd37: c = 32'h4bdecfa9;
            6'd38: c = 32'hf6bb4b60;  6'd39: c = 32'hbebfbc70;
            6'd40: c = 32'h289b7ec6;  6'd41: c = 32'heaa127fa;
            6'd42: c = 32'hd4ef3085;  6'd43: c = 32'h04881d05;
            6'd44: c = 32'hd9d4d039;  6'd45: c = 32'he6db99e5;
            6'd46: c = 32'h1fa27cf8;  6'd47: c = 32'hc4ac5665;
            6'd48: c = 32'hf4292244;  6'd49: c = 32'h432aff97;
            6'd50: c = 32'hab9423a7;  6'd51: c = 32'hfc93a039;
            6'd52: c = 32'h655b59c3;  6'd53: c = 32'h8f0ccc92;
            6'd54: c = 32'hffeff47d;  6'd55: c = 32'h85845dd1;
            6'd56: c = 32'h6fa87e4f;  6'd57: c = 32'hfe2ce6e0;
            6'd58: c = 32'ha3014314;  6'd59: c = 32'h4e0811a1;
            6'd60: c = 32'hf7537e82;  6'd61: c = 32'hbd3af235;
            6'd62: c = 32'h2ad7d2bb;  default: c = 32'heb86d391;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] k);
        logic [4:0] s;
        case ({k[5:4], k[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by step k.
    function automatic logic [3:0] msg_index(input logic [5:0] k);
        logic [3:0] i;
        logic [3:0] g;
        i = k[3:0];
        case (k[5:4])
            2'd0:    g = i;
            2'd1:    g = 4'({i, 2'b00} + i + 4'd1);
            2'd2:    g = 4'({i, 1'b0} + i + 4'd5);
            default: g = 4'({i, 2'b00} + {i, 1'b0} + i);
        endcase
        return g;
    endfunction

    // Final partial word: keep the valid bytes, pad byte right above them.
    function automatic logic [31:0] pad_last(input logic [31:0] w, input logic [1:0] nb);
        logic [31:0] r;
        case (nb)
            2'd0:    r = {24'h0, PAD_BYTE};
            2'd1:    r = {16'h0, PAD_BYTE, w[7:0]};
            2'd2:    r = {8'h0, PAD_BYTE, w[15:0]};
            default: r = {PAD_BYTE, w[23:0]};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

`default_nettype wire

[rtl/core/md5hc_buf_ram.sv]
// 16 x 32 message block buffer, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module md5hc_buf_ram (
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic [3:0]  rd_addr,
    output logic      [31:0] rd_data
);

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/md5hc_datapath.sv]
// MD5 step datapath: working registers A..D and chaining values.
// Depends on md5hc_pkg.
`default_nettype none

module md5hc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire md5hc_pkg::ctrl_t  ctrl,
    input  wire logic [5:0]        step_idx,
    input  wire logic [31:0]       m_word,
    output logic [3:0][31:0]       chain
);

    logic [3:0][31:0] chain_reg, chain_next;
    logic [3:0][31:0] rr_reg, rr_next;
    logic [31:0] a, b, c, d, f, sum, b_new;

    assign a = rr_reg[0];
    assign b = rr_reg[1];
    assign c = rr_reg[2];
    assign d = rr_reg[3];

    always_comb
    begin
        case (step_idx[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        sum   = a + f + md5hc_pkg::step_const(step_idx) + m_word;
        b_new = b + md5hc_pkg::rotl32(sum, md5hc_pkg::rot_amount(step_idx));
    end

    always_comb
    begin
        rr_next    = rr_reg;
        chain_next = chain_reg;
        if (ctrl.load)
        begin
            rr_next = chain_reg;
        end
        else if (ctrl.step)
        begin
            rr_next = {c, b, b_new, d};
        end
        if (ctrl.fin)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chain_next[i] = chain_reg[i] + rr_reg[i];
            end
        end
        else if (ctrl.clear)
        begin
            chain_next = md5hc_pkg::IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= md5hc_pkg::IV;
            rr_reg    <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            rr_reg    <= rr_next;
        end
    end

    assign chain = chain_reg;

endmodule

`default_nettype wire

[rtl/core/md5_hash_core_top.sv]
// MD5 message digest core. Words are written one per cycle, while the core is
// ready, into a 16-word block buffer; when the buffer fills, the 64 steps run
// one per cycle, each with its message word fetched ahead from the buffer RAM,
// then the chaining values are added. On the final word the padding and the
// 64-bit length are written one word per cycle, one or two blocks are
// compressed, and the four digest words (A first) are presented one per
// accepted request. Input is held off from the last word of a block until
// its compression ends, and from the final word until the last digest word
// is taken.
// Depends on md5hc_pkg, md5hc_buf_ram, md5hc_datapath, and the defines header.
`default_nettype none

`include "md5_hash_core_top_defines.svh"

module md5_hash_core_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        message_valid,
    output logic             message_ready,
    input  wire logic [31:0] message_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        end_of_message,
    output logic             digest_valid,
    input  wire logic        digest_ready,
    output logic      [31:0] digest_word,
    output logic      [1:0]  word_index,
    output logic             last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  round_reg, round_next;
    logic        pad80_reg, pad80_next;
    logic        msg_end_reg, msg_end_next;
    logic        len_lo_reg, len_lo_next;
    logic        digest_pend_reg, digest_pend_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;

    md5hc_pkg::ctrl_t ctrl;
    logic             accept;
    logic [2:0]       nb;
    logic             wr_en;
    logic [31:0]      wr_data;
    logic [3:0]       rd_addr;
    logic [31:0]      m_word;
    logic [3:0][31:0] chain;

    assign accept = message_valid && message_ready;
    assign nb     = (valid_bytes > md5hc_pkg::FULL_BYTES) ? md5hc_pkg::FULL_BYTES
                                                          : valid_bytes;
    // Step k consumes the word read during the cycle before it.
    assign rd_addr = (state_reg == S_ROUND) ? md5hc_pkg::msg_index(6'(round_reg + 6'd1))
                                            : 4'd0;

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        bitlen_next      = bitlen_reg;
        round_next       = round_reg;
        pad80_next       = pad80_reg;
        msg_end_next     = msg_end_reg;
        len_lo_next      = len_lo_reg;
        digest_pend_next = digest_pend_reg;
        out_idx_next     = out_idx_reg;
        out_valid_next   = out_valid_reg;
        ctrl             = '0;
        wr_en            = 1'b0;
        wr_data          = message_word;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wr_en    = 1'b1;
                    pos_next = 4'(pos_reg + 4'd1);
                    if (!end_of_message)
                    begin
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                    else
                    begin
                        bitlen_next  = bitlen_reg + {58'd0, nb, 3'b000};
                        msg_end_next = 1'b1;
                        pad80_next   = (nb == md5hc_pkg::FULL_BYTES);
                        if (nb != md5hc_pkg::FULL_BYTES)
                        begin
                            wr_data = md5hc_pkg::pad_last(message_word, nb[1:0]);
                        end
                    end
                    if (pos_reg == md5hc_pkg::LAST_POS)
                    begin
                        state_next = S_ROUND;
                        ctrl.load  = 1'b1;
                        round_next = '0;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                wr_en    = 1'b1;
                pos_next = 4'(pos_reg + 4'd1);
                if (pad80_reg)
                begin
                    wr_data    = {24'h0, md5hc_pkg::PAD_BYTE};
                    pad80_next = 1'b0;
                end
                else if (len_lo_reg)
                begin
                    wr_data          = bitlen_reg[63:32];
                    digest_pend_next = 1'b1;
                end
                else if (pos_reg == md5hc_pkg::LEN_POS)
                begin
                    wr_data     = bitlen_reg[31:0];
                    len_lo_next = 1'b1;
                end
                else
                begin
                    wr_data = '0;
                end
                if (pos_reg == md5hc_pkg::LAST_POS)
                begin
                    state_next = S_ROUND;
                    ctrl.load  = 1'b1;
                    round_next = '0;
                end
            end
            S_ROUND:
            begin
                ctrl.step  = 1'b1;
                round_next = 6'(round_reg + 6'd1);
                if (round_reg == md5hc_pkg::LAST_STEP)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                ctrl.fin = 1'b1;
                if (digest_pend_reg)
                begin
                    state_next     = S_OUT;
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                end
                else if (msg_end_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (digest_ready)
                begin
                    out_idx_next = 2'(out_idx_reg + 2'd1);
                    if (out_idx_reg == 2'd3)
                    begin
                        // digest taken: back to a fresh message
                        ctrl.clear       = 1'b1;
                        out_valid_next   = 1'b0;
                        pos_next         = '0;
                        bitlen_next      = '0;
                        pad80_next       = 1'b0;
                        msg_end_next     = 1'b0;
                        len_lo_next      = 1'b0;
                        digest_pend_next = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_reg         <= '0;
            bitlen_reg      <= '0;
            round_reg       <= '0;
            pad80_reg       <= 1'b0;
            msg_end_reg     <= 1'b0;
            len_lo_reg      <= 1'b0;
            digest_pend_reg <= 1'b0;
            out_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            bitlen_reg      <= bitlen_next;
            round_reg       <= round_next;
            pad80_reg       <= pad80_next;
            msg_end_reg     <= msg_end_next;
            len_lo_reg      <= len_lo_next;
            digest_pend_reg <= digest_pend_next;
            out_idx_reg     <= out_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    md5hc_buf_ram u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (m_word)
    );

    md5hc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .step_idx (round_reg),
        .m_word   (m_word),
        .chain    (chain)
    );

    assign message_ready = (state_reg == S_IDLE);
    assign digest_valid  = out_valid_reg;
    assign digest_word   = chain[out_idx_reg];
    assign word_index    = out_idx_reg;
    assign last_word     = (out_idx_reg == 2'd3);

    // buffer is never written while steps are reading it
    `MD5HC_NEVER(a_no_write_in_round, wr_en && (state_reg == S_ROUND), "buffer write during rounds")
    `MD5HC_NEVER(a_ready_xor_digest, message_ready && digest_valid, "input open while digest pending")
    `MD5HC_ASSERT(a_digest_order, digest_valid && digest_ready && !last_word |=> digest_valid && (word_index == 2'($past(word_index) + 2'd1)), "digest words out of order")
    `MD5HC_ASSERT(a_round_advance, (state_reg == S_ROUND) && (round_reg != md5hc_pkg::LAST_STEP) |=> (state_reg == S_ROUND) && (round_reg == 6'($past(round_reg) + 6'd1)), "step counter slipped")

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for md5_hash_core_top: streams message requests,
// predicts the four digest words of each message and checks them in order.
// Depends only on the md5_hash_core_top RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD = 10;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] PAD_MARK = 32'h00000080;
    localparam int FULL_WORD = 4;
    localparam logic [3:0] LENGTH_SLOT = 4'd14;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        eom;
    } msg_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic message_valid = 1'b0;
    logic message_ready;
    logic [31:0] message_word = '0;
    logic [2:0] valid_bytes = '0;
    logic end_of_message = 1'b0;
    logic digest_valid;
    logic digest_ready = 1'b0;
    logic [31:0] digest_word;
    logic [1:0] word_index;
    logic last_word;

    md5_hash_core_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .message_valid  (message_valid),
        .message_ready  (message_ready),
        .message_word   (message_word),
        .valid_bytes    (valid_bytes),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Per-step additive constants and rotate amounts of the MD5 rounds
    logic [31:0] md5_step_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int md5_shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Digest predictor state
    logic [31:0] hash_chain [4];
    logic [31:0] hash_blk [16];
    logic [3:0]  blk_pos;
    logic [63:0] msg_bits;

    msg_req_t    msg_q [$];
    digest_exp_t digest_q [$];
    msg_req_t    next_req;
    digest_exp_t got_exp;

    int errors = 0;
    int total_items = 0;
    int words_taken = 0;
    int quiet_cycles = 0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic clear_msg_state();
        hash_chain[0] = INIT_A;
        hash_chain[1] = INIT_B;
        hash_chain[2] = INIT_C;
        hash_chain[3] = INIT_D;
        blk_pos = '0;
        msg_bits = '0;
    endtask

    task automatic hash_block();
        logic [31:0] a, b, c, d, f, sum, t;
        int g;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int k = 0; k < 64; k++) begin
            case (k / 16)
                0: begin f = (b & c) | (~b & d); g = k % 16; end
                1: begin f = (b & d) | (c & ~d); g = (5 * k + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * k + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * k) % 16; end
            endcase
            sum = a + f + md5_step_k[k] + hash_blk[g];
            t = d;
            d = c;
            c = b;
            b = b + rol(sum, md5_shift[(k / 16) * 4 + k % 4]);
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
    endtask

    task automatic store_word(input logic [31:0] w);
        hash_blk[blk_pos] = w;
        blk_pos = blk_pos + 4'd1;
        if (blk_pos == 4'd0)
            hash_block();
    endtask

    task automatic predict_digest(input logic [31:0] w, input logic [2:0] vb, input logic eom);
        int nb;
        logic [31:0] mask;
        nb = (vb > FULL_WORD) ? FULL_WORD : int'(vb);
        if (!eom) begin
            // non-final words always count as full
            msg_bits += 64'd32;
            store_word(w);
        end
        else begin
            msg_bits += 64'(8 * nb);
            if (nb == FULL_WORD) begin
                store_word(w);
                store_word(PAD_MARK);
            end
            else begin
                mask = (nb == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * nb));
                store_word((w & mask) | (PAD_MARK << (8 * nb)));
            end
            while (blk_pos != LENGTH_SLOT)
                store_word(32'h0);
            store_word(msg_bits[31:0]);
            store_word(msg_bits[63:32]);
            for (int k = 0; k < 4; k++)
                digest_q.push_back('{hash_chain[k], 2'(k), k == 3});
            clear_msg_state();
        end
    endtask

    // 0: sender 28%, receiver 56%; 1: swapped; 2: no idling
    function automatic int stall_mode();
        if (total_items == 0)
            return 0;
        return (words_taken * 3) / total_items;
    endfunction

    function automatic int send_idle_pct();
        case (stall_mode())
            0: return 28;
            1: return 56;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (stall_mode())
            0: return 56;
            1: return 28;
            default: return 0;
        endcase
    endfunction

    task automatic add_req(input logic [31:0] w, input logic [2:0] nb, input logic eom);
        msg_q.push_back('{w, nb, eom});
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hffffffff;
        return $urandom;
    endfunction

    task automatic add_message(input int body_words);
        for (int i = 0; i < body_words; i++)
            add_req(rand_word(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                    1'b0);
        add_req(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic add_random_message();
        int r;
        r = $urandom_range(0, 9);
        // weight lengths near the block boundary, where padding spills over
        if (r < 4)
            add_message($urandom_range(0, 4));
        else if (r < 7)
            add_message($urandom_range(12, 16));
        else if (r < 9)
            add_message($urandom_range(5, 11));
        else
            add_message($urandom_range(28, 33));
    endtask

    // Request driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (message_valid && message_ready) begin
                predict_digest(message_word, valid_bytes, end_of_message);
                words_taken++;
            end
            if (!message_valid || message_ready) begin
                if (msg_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    next_req = msg_q.pop_front();
                    message_word <= next_req.word;
                    valid_bytes <= next_req.nbytes;
                    end_of_message <= next_req.eom;
                    message_valid <= 1'b1;
                end
                else
                    message_valid <= 1'b0;
            end
        end
    end

    // Digest monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (digest_valid && digest_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h (index %0d)", digest_word, word_index);
                    errors++;
                end
                else begin
                    got_exp = digest_q.pop_front();
                    if (digest_word !== got_exp.word) begin
                        $error("digest_word mismatch: expected %h, got %h",
                               got_exp.word, digest_word);
                        errors++;
                    end
                    if (word_index !== got_exp.index) begin
                        $error("word_index mismatch: expected %0d, got %0d",
                               got_exp.index, word_index);
                        errors++;
                    end
                    if (last_word !== got_exp.last) begin
                        $error("last_word mismatch: expected %0b, got %0b",
                               got_exp.last, last_word);
                        errors++;
                    end
                end
            end
            digest_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((message_valid && message_ready) || (digest_valid && digest_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_msg_state();

        // empty message: final word with no bytes
        add_req($urandom, 3'd0, 1'b1);
        // full final word, all ones
        add_req(32'hffffffff, 3'd4, 1'b1);
        // zero word, then a one-byte tail
        add_req(32'h00000000, 3'd4, 1'b0);
        add_req($urandom, 3'd1, 1'b1);
        add_req($urandom, 3'd2, 1'b1);
        // three-byte tail with junk in the top byte
        add_req(32'hff636261, 3'd3, 1'b1);
        // byte counts above four
        add_req($urandom, 3'd5, 1'b1);
        add_req($urandom, 3'd6, 1'b1);
        add_req($urandom, 3'd7, 1'b1);
        // short counts on non-final words are taken as full words
        add_req($urandom, 3'd3, 1'b0);
        add_req($urandom, 3'd0, 1'b0);
        add_req($urandom, 3'd7, 1'b0);
        add_req($urandom, 3'd2, 1'b1);

        while (msg_q.size() < 13 + RANDOM_ITEMS)
            add_random_message();
        total_items = msg_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken != total_items || digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && digest_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[md5_hash_core_top.f]
+incdir+rtl/core
rtl/core/md5hc_pkg.sv
rtl/core/md5hc_buf_ram.sv
rtl/core/md5hc_datapath.sv
rtl/core/md5_hash_core_top.sv
sim/tb.sv
